// ===== rtl/core/adaptive_cruise_speed_governor_defines.svh =====
// Assertion macros shared by the governor modules.
// Define NO_ASSERTIONS to compile them out.
`ifndef ADAPTIVE_CRUISE_SPEED_GOVERNOR_DEFINES_SVH
`define ADAPTIVE_CRUISE_SPEED_GOVERNOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted (active low).
`define ACSG_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
    else $error("acsg: assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ACSG_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
    else $error("acsg: assertion failed");

`else

`define ACSG_ASSERT_IMP(label, clk, rst, ante, cons)
`define ACSG_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/acsg_pkg.sv =====
`timescale 1ns / 1ps

package acsg_pkg;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned DIST_W    = 12;
  localparam int unsigned SPEED_W   = 7;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned MS_W      = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PROD_W    = DIST_W + SPEED_W;
  localparam int unsigned QUO_W     = SPEED_W;
  localparam int unsigned DIV_CNT_W = $clog2(QUO_W);

  localparam int unsigned IN_TDATA_W  = ((DIST_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELD_W = MODE_W + SPEED_W + 1 + ACT_W + 1 + DIST_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [SPEED_W-1:0] MAX_SPEED        = 7'd90;
  localparam logic [SPEED_W-1:0] EMERGENCY_STEP   = 7'd10;
  localparam logic [MS_W-1:0]    STEP_INTERVAL_MS = 32'd50;
  localparam logic [DIST_W-1:0]  FRONT_RESET      = 12'd500;

  localparam logic [SPEED_W-1:0] CRUISE_RESET     = 7'd50;
  localparam logic [DIST_W-1:0]  FOLLOW_RESET     = 12'd100;
  localparam logic [SPEED_W-1:0] MIN_SPEED_RESET  = 7'd20;
  localparam logic [DIST_W-1:0]  MIN_DIST_RESET   = 12'd20;
  localparam logic [DIST_W-1:0]  EMERG_RESET      = 12'd15;
  localparam logic [DIST_W-1:0]  SAFE_RESET       = 12'd100;
  localparam logic [SPEED_W-1:0] ACCEL_RESET      = 7'd2;
  localparam logic [SPEED_W-1:0] DECEL_RESET      = 7'd5;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 2'd0,
    CMD_SAMPLE  = 2'd1,
    CMD_ENABLE  = 2'd2,
    CMD_DISABLE = 2'd3
  } acsg_cmd_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_DISABLED  = 2'd0,
    MODE_ENABLED   = 2'd1,
    MODE_FOLLOWING = 2'd2,
    MODE_EMERGENCY = 2'd3
  } acsg_mode_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE         = 2'd0,
    ACT_FORWARD      = 2'd1,
    ACT_STOP         = 2'd2,
    ACT_STOP_FORWARD = 2'd3
  } acsg_action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CRUISE_SPEED    = 3'd0,
    REG_FOLLOW_DISTANCE = 3'd1,
    REG_MIN_SPEED       = 3'd2,
    REG_MIN_DISTANCE    = 3'd3,
    REG_EMERG_DISTANCE  = 3'd4,
    REG_SAFE_DISTANCE   = 3'd5,
    REG_ACCEL_STEP      = 3'd6,
    REG_DECEL_STEP      = 3'd7
  } acsg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_EVAL = 3'd1,
    ST_MUL  = 3'd2,
    ST_DIV  = 3'd3,
    ST_GOAL = 3'd4,
    ST_RAMP = 3'd5,
    ST_EMIT = 3'd6
  } acsg_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic eval;
    logic mul;
    logic div_step;
    logic goal;
    logic ramp;
    logic emit;
  } acsg_ctl_t;

  // Datapath to controller, valid during evaluation.
  typedef struct packed {
    logic need_div;
    logic need_ramp;
  } acsg_stat_t;

endpackage

// ===== rtl/core/acsg_ctrl.sv =====
`timescale 1ns / 1ps

`include "adaptive_cruise_speed_governor_defines.svh"

module acsg_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  acsg_pkg::acsg_stat_t stat,
  output acsg_pkg::acsg_ctl_t  ctl
);
  import acsg_pkg::*;

  acsg_state_t            state_r, state_nxt;
  logic [DIV_CNT_W-1:0]   div_cnt_r, div_cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    ctl         = '0;
    in_tready   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.load  = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        ctl.eval = 1'b1;
        if (stat.need_div) begin
          state_nxt = ST_MUL;
        end else if (stat.need_ramp) begin
          state_nxt = ST_RAMP;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_MUL: begin
        ctl.mul     = 1'b1;
        div_cnt_nxt = DIV_CNT_W'(QUO_W - 1);
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        ctl.div_step = 1'b1;
        if (div_cnt_r == '0) begin
          state_nxt = ST_GOAL;
        end else begin
          div_cnt_nxt = div_cnt_r - 1'b1;
        end
      end
      ST_GOAL: begin
        ctl.goal  = 1'b1;
        state_nxt = ST_RAMP;
      end
      ST_RAMP: begin
        ctl.ramp  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          ctl.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (ctl.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

  `ACSG_ASSERT_NXT(a_accept_starts_eval, clk, rst_n, in_tvalid && in_tready, state_r == ST_EVAL)
  `ACSG_ASSERT_IMP(a_no_result_overwrite, clk, rst_n, out_valid_r && !out_tready, !ctl.emit)
  `ACSG_ASSERT_NXT(a_div_ends, clk, rst_n, state_r == ST_DIV && div_cnt_r == '0, state_r == ST_GOAL)

endmodule

// ===== rtl/core/acsg_dp.sv =====
`timescale 1ns / 1ps

`include "adaptive_cruise_speed_governor_defines.svh"

module acsg_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  acsg_pkg::acsg_ctl_t                  ctl,
  output acsg_pkg::acsg_stat_t                 stat,
  input  logic [acsg_pkg::CMD_W-1:0]           in_cmd,
  input  logic [acsg_pkg::DIST_W-1:0]          in_dist,
  input  logic                                 cfg_we,
  input  logic [acsg_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [acsg_pkg::DIST_W-1:0]          cfg_wdata,
  output logic [acsg_pkg::OUT_TDATA_W-1:0]     out_data
);
  import acsg_pkg::*;

  // configuration
  logic [SPEED_W-1:0] cruise_r, cruise_nxt;
  logic [DIST_W-1:0]  follow_r, follow_nxt;
  logic [SPEED_W-1:0] min_speed_r, min_speed_nxt;
  logic [DIST_W-1:0]  min_dist_r, min_dist_nxt;
  logic [DIST_W-1:0]  emerg_r, emerg_nxt;
  logic [DIST_W-1:0]  safe_r, safe_nxt;
  logic [SPEED_W-1:0] accel_r, accel_nxt;
  logic [SPEED_W-1:0] decel_r, decel_nxt;

  // governor state
  acsg_mode_t         mode_r, mode_nxt;
  logic [SPEED_W-1:0] speed_r, speed_nxt;
  logic [DIST_W-1:0]  front_r, front_nxt;
  logic               brake_r, brake_nxt;
  logic [MS_W-1:0]    ms_r, ms_nxt;
  logic [MS_W-1:0]    last_step_r, last_step_nxt;

  // per-item working registers
  acsg_cmd_t          cmd_r, cmd_nxt;
  logic [DIST_W-1:0]  dist_r, dist_nxt;
  logic               written_r, written_nxt;
  acsg_action_t       action_r, action_nxt;
  logic [SPEED_W-1:0] goal_r, goal_nxt;
  logic [DIST_W-1:0]  num_r, num_nxt;
  logic [DIST_W-1:0]  den_r, den_nxt;
  logic [SPEED_W-1:0] span_r, span_nxt;
  logic [PROD_W-1:0]  rem_r, rem_nxt;
  logic [PROD_W-1:0]  den_sh_r, den_sh_nxt;
  logic [QUO_W-1:0]   quo_r, quo_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // decode of the held item
  logic [SPEED_W-1:0] t_raise, target, span;
  logic [DIST_W-1:0]  follow_eff;
  logic [MS_W-1:0]    elapsed;
  logic               step_due, running, emerg_hit, near, too_close, safe;
  logic [SPEED_W-1:0] spd_brake, diff_up, diff_dn, amt_up, amt_dn;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cruise_r    <= CRUISE_RESET;
      follow_r    <= FOLLOW_RESET;
      min_speed_r <= MIN_SPEED_RESET;
      min_dist_r  <= MIN_DIST_RESET;
      emerg_r     <= EMERG_RESET;
      safe_r      <= SAFE_RESET;
      accel_r     <= ACCEL_RESET;
      decel_r     <= DECEL_RESET;
      mode_r      <= MODE_DISABLED;
      speed_r     <= '0;
      front_r     <= FRONT_RESET;
      brake_r     <= 1'b0;
      ms_r        <= '0;
      last_step_r <= '0;
    end else begin
      cruise_r    <= cruise_nxt;
      follow_r    <= follow_nxt;
      min_speed_r <= min_speed_nxt;
      min_dist_r  <= min_dist_nxt;
      emerg_r     <= emerg_nxt;
      safe_r      <= safe_nxt;
      accel_r     <= accel_nxt;
      decel_r     <= decel_nxt;
      mode_r      <= mode_nxt;
      speed_r     <= speed_nxt;
      front_r     <= front_nxt;
      brake_r     <= brake_nxt;
      ms_r        <= ms_nxt;
      last_step_r <= last_step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    dist_r     <= dist_nxt;
    written_r  <= written_nxt;
    action_r   <= action_nxt;
    goal_r     <= goal_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    span_r     <= span_nxt;
    rem_r      <= rem_nxt;
    den_sh_r   <= den_sh_nxt;
    quo_r      <= quo_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    t_raise    = (cruise_r < min_speed_r) ? min_speed_r : cruise_r;
    target     = (t_raise > MAX_SPEED) ? MAX_SPEED : t_raise;
    span       = (target > min_speed_r) ? (target - min_speed_r) : '0;
    follow_eff = (follow_r < min_dist_r) ? min_dist_r : follow_r;
    elapsed    = ms_r - last_step_r;
    step_due   = (cmd_r == CMD_SAMPLE) && (elapsed >= STEP_INTERVAL_MS);
    running    = (mode_r == MODE_ENABLED) || (mode_r == MODE_FOLLOWING);
    emerg_hit  = dist_r <= emerg_r;
    near       = dist_r < follow_eff;
    too_close  = dist_r < min_dist_r;
    safe       = dist_r > safe_r;
    spd_brake  = (speed_r >= EMERGENCY_STEP) ? (speed_r - EMERGENCY_STEP) : '0;
    diff_up    = goal_r - speed_r;
    diff_dn    = speed_r - goal_r;
    amt_up     = (diff_up > accel_r) ? accel_r : diff_up;
    amt_dn     = (diff_dn > decel_r) ? decel_r : diff_dn;

    stat.need_ramp = step_due && running && !emerg_hit;
    stat.need_div  = stat.need_ramp && near && !too_close;
  end

  always_comb begin
    cruise_nxt    = cruise_r;
    follow_nxt    = follow_r;
    min_speed_nxt = min_speed_r;
    min_dist_nxt  = min_dist_r;
    emerg_nxt     = emerg_r;
    safe_nxt      = safe_r;
    accel_nxt     = accel_r;
    decel_nxt     = decel_r;
    mode_nxt      = mode_r;
    speed_nxt     = speed_r;
    front_nxt     = front_r;
    brake_nxt     = brake_r;
    ms_nxt        = ms_r;
    last_step_nxt = last_step_r;
    cmd_nxt       = cmd_r;
    dist_nxt      = dist_r;
    written_nxt   = written_r;
    action_nxt    = action_r;
    goal_nxt      = goal_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    span_nxt      = span_r;
    rem_nxt       = rem_r;
    den_sh_nxt    = den_sh_r;
    quo_nxt       = quo_r;
    out_data_nxt  = out_data_r;

    if (cfg_we) begin
      case (acsg_reg_t'(cfg_idx))
        REG_CRUISE_SPEED:    cruise_nxt    = cfg_wdata[SPEED_W-1:0];
        REG_FOLLOW_DISTANCE: follow_nxt    = cfg_wdata;
        REG_MIN_SPEED:       min_speed_nxt = cfg_wdata[SPEED_W-1:0];
        REG_MIN_DISTANCE:    min_dist_nxt  = cfg_wdata;
        REG_EMERG_DISTANCE:  emerg_nxt     = cfg_wdata;
        REG_SAFE_DISTANCE:   safe_nxt      = cfg_wdata;
        REG_ACCEL_STEP:      accel_nxt     = cfg_wdata[SPEED_W-1:0];
        REG_DECEL_STEP:      decel_nxt     = cfg_wdata[SPEED_W-1:0];
        default:             cruise_nxt    = cruise_r;
      endcase
    end

    if (ctl.load) begin
      cmd_nxt  = acsg_cmd_t'(in_cmd);
      dist_nxt = in_dist;
    end

    if (ctl.eval) begin
      written_nxt = 1'b0;
      action_nxt  = ACT_NONE;
      goal_nxt    = target;
      num_nxt     = dist_r - min_dist_r;
      den_nxt     = follow_eff - min_dist_r;
      span_nxt    = span;
      case (cmd_r)
        CMD_TICK: begin
          ms_nxt = ms_r + 1'b1;
        end
        CMD_SAMPLE: begin
          front_nxt = dist_r;
          if (step_due) begin
            last_step_nxt = ms_r;
            if (running) begin
              if (emerg_hit) begin
                mode_nxt = MODE_EMERGENCY;
              end else if (near) begin
                mode_nxt = MODE_FOLLOWING;
                if (too_close) begin
                  goal_nxt = min_speed_r;
                end
              end else begin
                mode_nxt = MODE_ENABLED;
              end
            end else if (mode_r == MODE_EMERGENCY) begin
              // brake a fixed step; resume once the path is clear
              if (speed_r != '0) begin
                speed_nxt   = spd_brake;
                written_nxt = 1'b1;
                brake_nxt   = 1'b1;
              end
              if (safe) begin
                mode_nxt   = MODE_ENABLED;
                brake_nxt  = 1'b0;
                action_nxt = (speed_r == '0) ? ACT_STOP_FORWARD : ACT_FORWARD;
              end else begin
                action_nxt = (speed_r == '0) ? ACT_STOP : ACT_NONE;
              end
            end
          end
        end
        CMD_ENABLE: begin
          speed_nxt   = min_speed_r;
          mode_nxt    = MODE_ENABLED;
          brake_nxt   = 1'b0;
          written_nxt = 1'b1;
          action_nxt  = ACT_FORWARD;
        end
        CMD_DISABLE: begin
          mode_nxt   = MODE_DISABLED;
          speed_nxt  = '0;
          brake_nxt  = 1'b0;
          action_nxt = ACT_STOP;
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end

    if (ctl.mul) begin
      rem_nxt    = PROD_W'(num_r) * PROD_W'(span_r);
      den_sh_nxt = PROD_W'(den_r) << (QUO_W - 1);
      quo_nxt    = '0;
    end

    // restoring division, one quotient bit per cycle, MSB first
    if (ctl.div_step) begin
      if (rem_r >= den_sh_r) begin
        rem_nxt = rem_r - den_sh_r;
        quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
      end else begin
        quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
      end
      den_sh_nxt = den_sh_r >> 1;
    end

    if (ctl.goal) begin
      goal_nxt = min_speed_r + quo_r;
    end

    if (ctl.ramp) begin
      if (goal_r > speed_r) begin
        speed_nxt   = speed_r + amt_up;
        written_nxt = 1'b1;
      end else if (goal_r < speed_r) begin
        speed_nxt   = speed_r - amt_dn;
        written_nxt = 1'b1;
      end
    end

    if (ctl.emit) begin
      out_data_nxt = OUT_TDATA_W'({front_r, brake_r, action_r, written_r, speed_r, mode_r});
    end
  end

  assign out_data = out_data_r;

  `ACSG_ASSERT_IMP(a_disabled_at_rest, clk, rst_n, mode_r == MODE_DISABLED, speed_r == '0 && !brake_r)
  `ACSG_ASSERT_IMP(a_brake_in_emergency, clk, rst_n, brake_r, mode_r == MODE_EMERGENCY)

endmodule

// ===== rtl/core/adaptive_cruise_speed_governor.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// in_      slave      in_tvalid/in_tready  tuser: cmd; tdata: distance_cm
// out_     master     out_tvalid/out_tready tdata: mode, speed_now, speed_written,
//                                          motor_action, brake_flag, front_seen
// cfg_     slave      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item at a time: ticks, commands and samples without a ramp pass through
// accept, evaluate and emit; a ramp toward a fixed goal adds a ramp step; a
// proportional target also adds a multiply step, a restoring divider and a goal step.
// rst_n is synchronous, active low, and restores configuration and governor state.
// A stalled output holds the next item in its final cycle; one more item may
// be taken while a finished result waits. cfg_ready is always high.

module adaptive_cruise_speed_governor (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [11:0] distance_cm, [15:12] zero
  input  logic [acsg_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [1:0] cmd
  input  logic [acsg_pkg::CMD_W-1:0]          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [1:0] mode, [8:2] speed_now, [9] speed_written, [11:10] motor_action,
  // [12] brake_flag, [24:13] front_seen, [31:25] zero
  output logic [acsg_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [acsg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [acsg_pkg::DIST_W-1:0]         cfg_data
);
  import acsg_pkg::*;

  acsg_ctl_t  ctl;
  acsg_stat_t stat;

  assign cfg_ready = 1'b1;

  acsg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .ctl        (ctl)
  );

  acsg_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .stat      (stat),
    .in_cmd    (in_tuser),
    .in_dist   (in_tdata[DIST_W-1:0]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .out_data  (out_tdata)
  );

endmodule
